// ----- hdl/packet_checksum_verifier_core_macros.svh -----
// ----------------------------------------------------------------------------
// packet_checksum_verifier_core_macros
// Assertion macros used by the checksum verifier sum core.
// ----------------------------------------------------------------------------
// Each macro expects clk and rst_n to be visible at the place of use.
`ifndef PACKET_CHECKSUM_VERIFIER_CORE_MACROS_SVH
`define PACKET_CHECKSUM_VERIFIER_CORE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define PCV_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A condition that must hold in the cycle after the trigger.
`define PCV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/pcv_pkg.sv -----
// ----------------------------------------------------------------------------
// pcv_pkg
// Types and constants shared by the packet checksum verifier modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcv_pkg;

    localparam int unsigned MOD_SUM     = 255;
    localparam int unsigned MIN_LENGTH  = 4;
    localparam int unsigned SYNC_BYTES  = 4;
    localparam int unsigned PRIM_HEADER = 10;
    localparam int unsigned FULL_HEADER = 11;

    // Offsets from the length to the trailer positions.
    localparam int unsigned SUM_END_OFS  = 6;
    localparam int unsigned SENT_SIMPLE  = 7;
    localparam int unsigned SENT_FLETCH  = 8;
    localparam int unsigned SENT_WIDE_HI = 9;
    localparam int unsigned LAST_OFS     = FULL_HEADER - 1;

    localparam int unsigned INDEX_W = 17;
    localparam int unsigned LEN_W   = 16;

    localparam logic [2:0] MASK_SIMPLE  = 3'b001;
    localparam logic [2:0] MASK_FLETCH  = 3'b010;
    localparam logic [2:0] MASK_WIDE    = 3'b100;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic             first_byte;
        logic [LEN_W-1:0] pkt_len;
    } item_t;

    typedef struct packed {
        logic [2:0]  match_mask;
        logic [7:0]  simple_sum;
        logic [7:0]  fletcher_sum;
        logic [15:0] byte_sum;
    } result_t;

    // Handshake between the sum core and the neighboring stages.
    typedef struct packed {
        logic advance;
        logic emit;
    } core_ctrl_t;

endpackage

// ----- hdl/pcv_in_reg.sv -----
// ----------------------------------------------------------------------------
// pcv_in_reg
// Input register: holds one request until the sum core consumes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcv_in_reg
    import pcv_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  byte_valid,
    output logic  byte_stall,
    input  item_t item_in,
    input  logic  advance,
    output logic  item_valid,
    output item_t item_out
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    // The register may refill in the same cycle that the core consumes it.
    assign byte_stall = valid_reg && !advance;
    assign load       = byte_valid && !byte_stall;
    assign valid_next = load || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_in;
        end
    end

    assign item_valid = valid_reg;
    assign item_out   = item_reg;

endmodule

// ----- hdl/pcv_sum_core.sv -----
// ----------------------------------------------------------------------------
// pcv_sum_core
// Packet position tracking, running checksums and trailer comparison.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "packet_checksum_verifier_core_macros.svh"

module pcv_sum_core
    import pcv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  item_t      item,
    input  logic       out_free,
    output core_ctrl_t ctrl,
    output result_t    result
);

    logic [INDEX_W-1:0] byte_index_reg, byte_index_next;
    logic [LEN_W-1:0]   length_reg, length_next;
    logic [7:0]         simple_acc_reg, simple_acc_next;
    logic [7:0]         fletcher_acc_reg, fletcher_acc_next;
    logic [15:0]        wide_acc_reg, wide_acc_next;
    logic [7:0]         sent_simple_reg, sent_simple_next;
    logic [7:0]         sent_fletcher_reg, sent_fletcher_next;
    logic [7:0]         sent_wide_high_reg, sent_wide_high_next;

    logic [INDEX_W-1:0] pos;
    logic [INDEX_W-1:0] len_ext;
    logic               active;
    logic               in_simple;
    logic               in_wide;
    logic               emit;
    logic               advance;
    logic [7:0]         base_simple;
    logic [7:0]         base_fletcher;
    logic [15:0]        base_wide;
    logic [7:0]         base_sent_simple;
    logic [7:0]         base_sent_fletcher;
    logic [7:0]         base_sent_wide_high;
    logic [8:0]         simple_add;
    logic [7:0]         simple_mod;
    logic [8:0]         fletcher_add;
    logic [7:0]         fletcher_mod;

    always_comb
    begin
        pos     = item.first_byte ? '0 : byte_index_reg;
        len_ext = item.first_byte ? {1'b0, item.pkt_len} : {1'b0, length_reg};
        active  = item.first_byte ? (item.pkt_len >= LEN_W'(MIN_LENGTH))
                                  : (byte_index_reg != '0);

        in_simple = (pos >= INDEX_W'(PRIM_HEADER))
                 && (pos <= len_ext + INDEX_W'(SUM_END_OFS));
        in_wide   = (pos >= INDEX_W'(SYNC_BYTES))
                 && (pos <= len_ext + INDEX_W'(SENT_FLETCH));
        emit      = active && (pos == len_ext + INDEX_W'(LAST_OFS));
        advance   = item_valid && (!emit || out_free);

        // A first byte restarts every sum from zero.
        base_simple         = item.first_byte ? '0 : simple_acc_reg;
        base_fletcher       = item.first_byte ? '0 : fletcher_acc_reg;
        base_wide           = item.first_byte ? '0 : wide_acc_reg;
        base_sent_simple    = item.first_byte ? '0 : sent_simple_reg;
        base_sent_fletcher  = item.first_byte ? '0 : sent_fletcher_reg;
        base_sent_wide_high = item.first_byte ? '0 : sent_wide_high_reg;

        // The sum stays below 255 plus 255, so one subtraction reduces it.
        simple_add = {1'b0, base_simple} + {1'b0, item.data_byte};
        simple_mod = (simple_add >= 9'(MOD_SUM)) ? 8'(simple_add - 9'(MOD_SUM))
                                                 : simple_add[7:0];
        fletcher_add = {1'b0, base_fletcher} + {1'b0, simple_mod};
        fletcher_mod = (fletcher_add >= 9'(MOD_SUM)) ? 8'(fletcher_add - 9'(MOD_SUM))
                                                     : fletcher_add[7:0];

        length_next         = item.first_byte ? item.pkt_len : length_reg;
        simple_acc_next     = base_simple;
        fletcher_acc_next   = base_fletcher;
        wide_acc_next       = base_wide;
        sent_simple_next    = base_sent_simple;
        sent_fletcher_next  = base_sent_fletcher;
        sent_wide_high_next = base_sent_wide_high;
        byte_index_next     = '0;

        if (active)
        begin
            if (in_simple)
            begin
                simple_acc_next   = simple_mod;
                fletcher_acc_next = fletcher_mod;
            end
            if (in_wide)
            begin
                wide_acc_next = base_wide + {8'd0, item.data_byte};
            end
            if (pos == len_ext + INDEX_W'(SENT_SIMPLE))
            begin
                sent_simple_next = item.data_byte;
            end
            else if (pos == len_ext + INDEX_W'(SENT_FLETCH))
            begin
                sent_fletcher_next = item.data_byte;
            end
            else if (pos == len_ext + INDEX_W'(SENT_WIDE_HI))
            begin
                sent_wide_high_next = item.data_byte;
            end
            byte_index_next = emit ? '0 : pos + INDEX_W'(1);
        end

        result.match_mask = '0;
        if (simple_acc_next == base_sent_simple)
        begin
            result.match_mask = result.match_mask | MASK_SIMPLE;
        end
        if (fletcher_acc_next == base_sent_fletcher)
        begin
            result.match_mask = result.match_mask | MASK_FLETCH;
        end
        if (wide_acc_next == {base_sent_wide_high, item.data_byte})
        begin
            result.match_mask = result.match_mask | MASK_WIDE;
        end
        result.simple_sum   = simple_acc_next;
        result.fletcher_sum = fletcher_acc_next;
        result.byte_sum     = wide_acc_next;
    end

    assign ctrl.advance = advance;
    assign ctrl.emit    = emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg     <= '0;
            length_reg         <= '0;
            simple_acc_reg     <= '0;
            fletcher_acc_reg   <= '0;
            wide_acc_reg       <= '0;
            sent_simple_reg    <= '0;
            sent_fletcher_reg  <= '0;
            sent_wide_high_reg <= '0;
        end
        else if (advance)
        begin
            byte_index_reg     <= byte_index_next;
            length_reg         <= length_next;
            simple_acc_reg     <= simple_acc_next;
            fletcher_acc_reg   <= fletcher_acc_next;
            wide_acc_reg       <= wide_acc_next;
            sent_simple_reg    <= sent_simple_next;
            sent_fletcher_reg  <= sent_fletcher_next;
            sent_wide_high_reg <= sent_wide_high_next;
        end
    end

    `PCV_ASSERT_ALWAYS(a_index_in_packet,
        byte_index_reg <= {1'b0, length_reg} + INDEX_W'(LAST_OFS),
        "byte index ran past the end of the packet")
    `PCV_ASSERT_ALWAYS(a_mod_range,
        (simple_acc_reg != 8'hFF) && (fletcher_acc_reg != 8'hFF),
        "mod-255 accumulator left its range")
    `PCV_ASSERT_NEXT(a_emit_goes_idle, advance && emit,
        byte_index_reg == '0, "block did not go idle after the final byte")
    `PCV_ASSERT_NEXT(a_index_steps,
        advance && !item.first_byte && (byte_index_reg != '0) && !emit,
        byte_index_reg == $past(byte_index_reg) + INDEX_W'(1),
        "byte index did not step by one inside a packet")

endmodule

// ----- hdl/pcv_out_reg.sv -----
// ----------------------------------------------------------------------------
// pcv_out_reg
// Result register: holds a finished result until the consumer takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pcv_out_reg
    import pcv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  core_ctrl_t ctrl,
    input  result_t    result_in,
    input  logic       result_stall,
    output logic       out_free,
    output logic       result_valid,
    output result_t    result_out
);

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;
    logic    load;

    assign out_free   = !valid_reg || !result_stall;
    assign load       = ctrl.advance && ctrl.emit;
    assign valid_next = load || (valid_reg && result_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign result_valid = valid_reg;
    assign result_out   = result_reg;

endmodule

// ----- hdl/packet_checksum_verifier_core.sv -----
// ----------------------------------------------------------------------------
// packet_checksum_verifier_core: one byte per cycle unless a final byte meets a stalled result reg.
// A final byte's result leaves through the input register and then the result register.
// Asynchronous active-low reset clears all sums and leaves the block idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module packet_checksum_verifier_core
    import pcv_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             byte_valid,
    output logic             byte_stall,
    input  logic [7:0]       data_byte,
    input  logic             first_byte,
    input  logic [LEN_W-1:0] pkt_len,
    output logic             result_valid,
    input  logic             result_stall,
    output logic [2:0]       match_mask,
    output logic [7:0]       simple_sum,
    output logic [7:0]       fletcher_sum,
    output logic [15:0]      byte_sum
);

    item_t      item_in;
    item_t      item;
    logic       item_valid;
    logic       out_free;
    core_ctrl_t ctrl;
    result_t    core_result;
    result_t    result_out;

    assign item_in.data_byte  = data_byte;
    assign item_in.first_byte = first_byte;
    assign item_in.pkt_len    = pkt_len;

    pcv_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .item_in    (item_in),
        .advance    (ctrl.advance),
        .item_valid (item_valid),
        .item_out   (item)
    );

    pcv_sum_core u_sum_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .ctrl       (ctrl),
        .result     (core_result)
    );

    pcv_out_reg u_out_reg (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .result_in    (core_result),
        .result_stall (result_stall),
        .out_free     (out_free),
        .result_valid (result_valid),
        .result_out   (result_out)
    );

    assign match_mask   = result_out.match_mask;
    assign simple_sum   = result_out.simple_sum;
    assign fletcher_sum = result_out.fletcher_sum;
    assign byte_sum     = result_out.byte_sum;

endmodule
